>>> src/swrl_pkg.sv
`timescale 1ns / 1ps

package swrl_pkg;

   localparam int CLIENT_SLOTS_DEF = 8;
   localparam int RING_DEPTH_DEF   = 512;

   localparam int STAMP_W = 32;
   localparam int SLOT_W_PORT = 3;
   localparam int CFG_W = 16;
   localparam int COUNT_OUT_W = 10;

   localparam logic [CFG_W-1:0]       REQUEST_LIMIT_RESET  = 16'd300;
   localparam logic [CFG_W-1:0]       WINDOW_SECONDS_RESET = 16'd60;
   localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX        = 10'd1023;

   // register select: word address bit 2 picks the register
   localparam logic REG_SEL_REQUEST_LIMIT  = 1'b0;
   localparam logic REG_SEL_WINDOW_SECONDS = 1'b1;

   typedef struct packed {
      logic [STAMP_W-1:0] diff;
      logic               borrow;
   } sub_res_type;

endpackage

>>> src/swrl_stamp_mem.sv
`timescale 1ns / 1ps

module swrl_stamp_mem
   import swrl_pkg::*;
#(
   parameter int ADDR_W = 12
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [STAMP_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [STAMP_W-1:0] rd_data
);

   logic [STAMP_W-1:0] stamp_mem_ff [2**ADDR_W];
   logic [STAMP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stamp_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/swrl_sub_unit.sv
`timescale 1ns / 1ps

module swrl_sub_unit
   import swrl_pkg::*;
(
   input  logic [STAMP_W-1:0] op_a,
   input  logic [STAMP_W-1:0] op_b,
   output sub_res_type        res
);

   logic [STAMP_W:0] wide_diff;

   // borrow set means op_a < op_b
   assign wide_diff  = {1'b0, op_a} - {1'b0, op_b};
   assign res.diff   = wide_diff[STAMP_W-1:0];
   assign res.borrow = wide_diff[STAMP_W];

endmodule

>>> src/sliding_window_rate_limiter.sv
`timescale 1ns / 1ps

// Sliding-window rate limiter, one ring of time stamps per client slot.
// Request channel (req_*): a word carries a client slot and the current time in
// seconds. Response channel (rsp_*): a word carries the allow bit and the number of
// stored stamps of that slot inside the window, one response per request.
// The csr_* port sets the request limit (address 0) and window length (address 4).
// One request is worked at a time; req_ready is high only while the sequencer idles.
// A request scans the fill of its slot through the stamp memory, one read a cycle
// through a single registered read port, with one shared subtractor doing the
// window start, each stamp compare and the final limit compare.
// A slot number beyond the configured slots is answered allowed with count 0, without a scan.
// The result sits in an output register; if the receiver stalls, the next request is
// still accepted and scanned, and it waits to commit until the held response is taken.
// Reset clears the heads and fill counts of all slots and restores the register
// defaults; the stamp memory itself is not cleared and needs no clearing pass.

module sliding_window_rate_limiter
   import swrl_pkg::*;
#(
   parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF,
   parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SLOT_W_PORT-1:0] req_client_slot,
   input  logic [STAMP_W-1:0]     req_now_seconds,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_allowed,
   output logic [COUNT_OUT_W-1:0] rsp_recent_count,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int SLOT_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int ADDR_W = SLOT_W + IDX_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_START  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_SPARE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] limit_ff, limit_in;
   logic [CFG_W-1:0] window_ff, window_in;

   logic [SLOT_W_PORT-1:0] slot_ff, slot_in;
   logic [STAMP_W-1:0]     now_ff, now_in;
   logic [STAMP_W-1:0]     win_start_ff, win_start_in;
   logic                   slot_bad_ff, slot_bad_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rd_pend_ff, rd_pend_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_allowed_ff, rsp_allowed_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [IDX_W-1:0] ring_head_ff [CLIENT_SLOTS];
   logic [CNT_W-1:0] fill_count_ff [CLIENT_SLOTS];
   logic [IDX_W-1:0] head_in;
   logic [CNT_W-1:0] slot_fill_in;
   logic             commit;

   logic [SLOT_W-1:0] slot_idx;
   logic              slot_ok;

   logic [STAMP_W-1:0] op_a, op_b;
   sub_res_type        sub_res;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [STAMP_W-1:0] mem_rd_data;

   logic csr_wr;
   logic out_free;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      limit_in  = limit_ff;
      window_in = window_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_SEL_REQUEST_LIMIT:  limit_in  = csr_pwdata[CFG_W-1:0];
            REG_SEL_WINDOW_SECONDS: window_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SEL_REQUEST_LIMIT:  csr_prdata = {16'd0, limit_ff};
         REG_SEL_WINDOW_SECONDS: csr_prdata = {16'd0, window_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // shared subtractor and its operand selection
   always_comb begin
      case (state_ff)
         ST_START: begin
            op_a = now_ff;
            op_b = STAMP_W'(window_ff);
         end
         ST_SCAN: begin
            op_a = mem_rd_data;
            op_b = win_start_ff;
         end
         ST_DECIDE: begin
            op_a = STAMP_W'(count_ff);
            op_b = STAMP_W'(limit_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   swrl_sub_unit u_sub (
      .op_a (op_a),
      .op_b (op_b),
      .res  (sub_res)
   );

   assign slot_idx = SLOT_W'(slot_ff);
   assign slot_ok  = 32'(slot_ff) < CLIENT_SLOTS;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      now_in         = now_ff;
      win_start_in   = win_start_ff;
      slot_bad_in    = slot_bad_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      rd_pend_in     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_count_in   = rsp_count_ff;
      mem_rd_en      = 1'b0;
      commit         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               slot_in  = req_client_slot;
               now_in   = req_now_seconds;
               state_in = ST_START;
            end
         end
         ST_START: begin
            // window start saturates at zero
            win_start_in = sub_res.borrow ? '0 : sub_res.diff;
            slot_bad_in  = !slot_ok;
            fill_in      = slot_ok ? fill_count_ff[slot_idx] : '0;
            idx_in       = '0;
            count_in     = '0;
            state_in     = slot_ok ? ST_SCAN : ST_DECIDE;
         end
         ST_SCAN: begin
            if (rd_pend_ff && !sub_res.borrow) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (idx_ff != fill_ff) begin
               mem_rd_en  = 1'b1;
               rd_pend_in = 1'b1;
               idx_in     = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = slot_bad_ff || sub_res.borrow;
               rsp_count_in   = (32'(count_ff) > 32'(COUNT_OUT_MAX)) ?
                                COUNT_OUT_MAX : COUNT_OUT_W'(count_ff);
               commit         = !slot_bad_ff && sub_res.borrow;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_rd_addr = {slot_idx, idx_ff[IDX_W-1:0]};

   // ring head wraps at the ring depth, fill saturates there
   always_comb begin
      head_in      = (ring_head_ff[slot_idx] == IDX_W'(RING_DEPTH - 1)) ?
                     '0 : ring_head_ff[slot_idx] + IDX_W'(1);
      slot_fill_in = (fill_count_ff[slot_idx] < CNT_W'(RING_DEPTH)) ?
                     fill_count_ff[slot_idx] + CNT_W'(1) : fill_count_ff[slot_idx];
   end

   assign mem_wr_en   = commit;
   assign mem_wr_addr = {slot_idx, ring_head_ff[slot_idx]};

   swrl_stamp_mem #(
      .ADDR_W (ADDR_W)
   ) u_stamp_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (now_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= REQUEST_LIMIT_RESET;
         window_ff    <= WINDOW_SECONDS_RESET;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_bad_ff  <= 1'b0;
         idx_ff       <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         for (int s = 0; s < CLIENT_SLOTS; s++) begin
            ring_head_ff[s]  <= '0;
            fill_count_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         window_ff    <= window_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_bad_ff  <= slot_bad_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         if (commit) begin
            ring_head_ff[slot_idx]  <= head_in;
            fill_count_ff[slot_idx] <= slot_fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      now_ff         <= now_in;
      win_start_ff   <= win_start_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_allowed      = rsp_allowed_ff;
   assign rsp_recent_count = rsp_count_ff;

   a_write_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_DECIDE) && !slot_bad_ff && out_free)
      else $error("stamp written outside a committing decision");

   a_scan_index_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= fill_ff))
      else $error("scan index ran past the fill count");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DECIDE) |-> (count_ff <= fill_ff))
      else $error("window count exceeds stamps read");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && !slot_bad_ff) |->
         (fill_count_ff[slot_idx] <= CNT_W'(RING_DEPTH)))
      else $error("slot fill count beyond ring depth");

   a_busy_while_scanning: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> !$past(req_ready))
      else $error("request taken while a scan was running");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import swrl_pkg::*;

   localparam int SLOTS       = CLIENT_SLOTS_DEF;
   localparam int DEPTH       = RING_DEPTH_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [SLOT_W_PORT-1:0] slot;
      logic [STAMP_W-1:0]     now;
   } rate_req_type;

   typedef struct {
      logic                   allowed;
      logic [COUNT_OUT_W-1:0] count;
   } verdict_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SLOT_W_PORT-1:0] req_client_slot = '0;
   logic [STAMP_W-1:0]     req_now_seconds = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_allowed;
   logic [COUNT_OUT_W-1:0] rsp_recent_count;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [2:0]             csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   rate_req_type req_backlog[$];
   verdict_type  verdicts_due[$];

   // shadow of the limiter state
   logic [CFG_W-1:0]   limit_cfg = REQUEST_LIMIT_RESET;
   logic [CFG_W-1:0]   window_cfg = WINDOW_SECONDS_RESET;
   logic [STAMP_W-1:0] stamp_log[SLOTS][DEPTH];
   int unsigned        ring_pos[SLOTS];
   int unsigned        ring_fill[SLOTS];

   int unsigned words_in = 0;
   int unsigned errors = 0;
   int unsigned stall_cycles = 0;
   logic        req_fired = 1'b0;

   sliding_window_rate_limiter u_top (.*);

   always #1 clock = ~clock;

   function automatic verdict_type judge_request(logic [SLOT_W_PORT-1:0] slot,
                                                 logic [STAMP_W-1:0] now);
      verdict_type        v;
      logic [STAMP_W-1:0] start;
      int unsigned        hits;
      start = (now >= {16'd0, window_cfg}) ? now - {16'd0, window_cfg} : '0;
      hits = 0;
      for (int i = 0; i < ring_fill[slot]; i++) begin
         if (stamp_log[slot][i] >= start) hits++;
      end
      v.count = (hits > COUNT_OUT_MAX) ? COUNT_OUT_MAX : hits[COUNT_OUT_W-1:0];
      v.allowed = (hits < limit_cfg);
      if (v.allowed) begin
         // oldest stamp at the head is overwritten once the ring is full
         stamp_log[slot][ring_pos[slot]] = now;
         ring_pos[slot] = (ring_pos[slot] + 1) % DEPTH;
         if (ring_fill[slot] < DEPTH) ring_fill[slot]++;
      end
      return v;
   endfunction

   function automatic void note_mismatch(string what, int unsigned due, int unsigned got);
      if (errors < 10) $display("%s: expected %0d, got %0d", what, due, got);
      errors++;
   endfunction

   // request driver
   always @(negedge clock) begin : drive_req
      int unsigned  gap;
      rate_req_type nxt;
      gap = (words_in < 390) ? 17 : (words_in < 780) ? 79 : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= gap) begin
            nxt = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_client_slot <= nxt.slot;
            req_now_seconds <= nxt.now;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin : drive_rsp
      int unsigned gap;
      gap = (words_in < 390) ? 79 : (words_in < 780) ? 17 : 0;
      rsp_ready <= ($urandom_range(99) >= gap);
   end

   always @(posedge clock) begin : watch_words
      verdict_type due;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_ready;
         // check the response before queueing a new word's prediction
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               note_mismatch("unexpected response word, count", 0, rsp_recent_count);
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_allowed !== due.allowed)
                  note_mismatch("allowed", due.allowed, rsp_allowed);
               if (rsp_recent_count !== due.count)
                  note_mismatch("recent_count", due.count, rsp_recent_count);
            end
         end
         if (req_valid && req_ready) begin
            verdicts_due.push_back(judge_request(req_client_slot, req_now_seconds));
            words_in++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   task automatic offer(int unsigned slot, logic [STAMP_W-1:0] now);
      rate_req_type r;
      r.slot = slot[SLOT_W_PORT-1:0];
      r.now = now;
      req_backlog.push_back(r);
   endtask

   task automatic drain();
      while (req_backlog.size() != 0 || req_valid || verdicts_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic sel, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (sel == REG_SEL_REQUEST_LIMIT) limit_cfg = value;
      else window_cfg = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_limits(int unsigned lim, int unsigned win);
      drain();
      write_reg(REG_SEL_REQUEST_LIMIT, lim[CFG_W-1:0]);
      write_reg(REG_SEL_WINDOW_SECONDS, win[CFG_W-1:0]);
   endtask

   initial begin : stimulus
      int unsigned        lim;
      int unsigned        win;
      int unsigned        step;
      logic [STAMP_W-1:0] wall;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults, early time and the ends of the time range
      offer(0, 0);
      offer(0, 5);
      offer(7, '1);
      offer(7, '1);
      offer(5, 32'h8000_0000);
      offer(2, 59);
      // zero limit refuses everything
      set_limits(0, 16'hFFFF);
      offer(0, 10);
      offer(3, 0);
      // zero window: only stamps of the same second count
      set_limits(16'hFFFF, 0);
      offer(1, 100);
      offer(1, 100);
      offer(1, 100);
      offer(1, 101);
      // tight limit on a one second window
      set_limits(2, 1);
      offer(4, 1000);
      offer(4, 1000);
      offer(4, 1000);
      offer(4, 1001);
      offer(4, 1002);

      // one slot hammered until its ring wraps
      set_limits(16'hFFFF, 16'hFFFF);
      wall = 32'd5000;
      for (int n = 0; n < 540; n++) begin
         wall += $urandom_range(0, 3);
         offer(6, wall);
      end

      // mixed traffic paced to hover around the limit, last phase crosses time wrap
      for (int p = 0; p < 4; p++) begin
         lim = $urandom_range(1, 20);
         win = $urandom_range(1, 100);
         step = (2 * win) / (SLOTS * lim);
         if (p == 3) wall = 32'hFFFF_FFFF - (130 * (step + 1)) / 4;
         set_limits(lim, win);
         for (int n = 0; n < 130; n++) begin
            wall += $urandom_range(0, step + 1);
            offer($urandom_range(0, SLOTS - 1), wall);
         end
      end

      // scattered times over the whole range
      set_limits($urandom_range(0, 3), $urandom_range(1, 16'hFFFF));
      for (int n = 0; n < 90; n++) offer($urandom_range(0, SLOTS - 1), $urandom());

      drain();
      repeat (DEPTH + 8) @(posedge clock);
      if (errors == 0 && verdicts_due.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/swrl_pkg.sv
src/swrl_stamp_mem.sv
src/swrl_sub_unit.sv
src/sliding_window_rate_limiter.sv
dv/tb.sv
